// File: design/pfc_pkg.sv
// Shared types and constants for the prime factor counter.
package pfc_pkg;

    localparam int COUNT_W = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// File: design/prime_factor_counter.sv
// Prime factor counter: counts prime factors with multiplicity by trial division.
//
// Input channel: i_valid / o_stall carrying i_value (VALUE_BITS bits, unsigned).
// Output channel: o_valid / i_stall carrying o_factor_count (5 bits, unsigned).
// A beat moves when valid is high and stall is low at a rising edge of i_clk.
// Each input beat yields exactly one output beat; 0 and 1 give a count of 0.
// The count saturates at 31.
// One serial restoring divider is shared by every trial step. Each trial
// division runs bit-serially in ST_DIV and is followed by a check in ST_CHECK;
// after the last check the item waits in ST_DONE until the output register is
// free. The number of divisions is about the number of trial divisors up to
// the square root of the final remainder plus one per prime factor found:
// about 23200 for a prime near 2^31.
// o_stall is high while an item is being worked on. A finished count sits in
// the output register until taken; the next item may be accepted meanwhile,
// and its result waits until the register is free.
// i_rst_n is synchronous and active low; it clears the sequencer and the
// output valid, and the block is ready in the next cycle.
module prime_factor_counter #(
    parameter int VALUE_BITS = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [VALUE_BITS-1:0]       i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [pfc_pkg::COUNT_W-1:0] o_factor_count
);
    import pfc_pkg::*;

    localparam int DB = (VALUE_BITS + 1) / 2 + 1;
    localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam logic [BW-1:0] LAST_BIT = BW'(VALUE_BITS - 1);

    t_state                 r_state, n_state;
    logic [VALUE_BITS-1:0]  r_rem,   n_rem;
    logic [VALUE_BITS-1:0]  r_quo,   n_quo;
    logic [DB-1:0]          r_part,  n_part;
    logic [DB-1:0]          r_div,   n_div;
    logic [BW-1:0]          r_bit,   n_bit;
    logic [COUNT_W-1:0]     r_cnt,   n_cnt;
    logic                   r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]     r_out_cnt,   n_out_cnt;

    logic [DB:0]            trial;
    logic [DB:0]            diff;
    logic                   out_free;

    assign trial    = {r_part, r_quo[VALUE_BITS-1]};
    assign diff     = trial - {1'b0, r_div};
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_part      = r_part;
        n_div       = r_div;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_cnt   = r_out_cnt;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_rem   = i_value;
                    n_quo   = i_value;
                    n_part  = '0;
                    n_div   = DB'(2);
                    n_bit   = LAST_BIT;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!diff[DB]) begin
                    n_part = diff[DB-1:0];
                    n_quo  = {r_quo[VALUE_BITS-2:0], 1'b1};
                end else begin
                    n_part = trial[DB-1:0];
                    n_quo  = {r_quo[VALUE_BITS-2:0], 1'b0};
                end
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (VALUE_BITS'(r_div) > r_quo) begin
                    if (r_rem > VALUE_BITS'(1)) begin
                        n_cnt = sat_inc(r_cnt);
                    end
                    n_state = ST_DONE;
                end else begin
                    if (r_part == '0) begin
                        n_rem = r_quo;
                        n_cnt = sat_inc(r_cnt);
                    end else begin
                        n_div = r_div + ((r_div == DB'(2)) ? DB'(1) : DB'(2));
                    end
                    n_quo   = (r_part == '0) ? r_quo : r_rem;
                    n_part  = '0;
                    n_bit   = LAST_BIT;
                    n_state = ST_DIV;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = r_cnt;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_div     <= DB'(2);
            r_cnt     <= '0;
            r_out_cnt <= '0;
        end else begin
            r_rem     <= n_rem;
            r_div     <= n_div;
            r_cnt     <= n_cnt;
            r_out_cnt <= n_out_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_part <= n_part;
        r_bit  <= n_bit;
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_factor_count = r_out_cnt;

endmodule
